### hdl/dvd_pkg.sv
// Shared types and constants for the delta varint decoder.
// Depends on nothing; every other file of the decoder imports it.

package dvd_pkg;

  // Address and code geometry.
  localparam int unsigned AddrWidthDefault = 64;
  localparam int unsigned AddrFieldWidth   = 64;
  localparam int unsigned PosWidth         = 7;
  localparam int unsigned CapWidth         = 32;

  localparam logic [7:0]          DataMask    = 8'h7F;
  localparam logic [7:0]          MoreBit     = 8'h80;
  localparam logic [PosWidth-1:0] GroupBits   = 7'd7;
  localparam logic [PosWidth-1:0] OverflowPos = 7'd127;

  localparam logic [CapWidth-1:0] CapReset = 32'hFFFF_FFFF;

  // Command queue between front and back.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrWidth  = $clog2(QueueDepth);
  localparam int unsigned QCntWidth  = $clog2(QueueDepth + 1);

  // Result status codes.
  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusTruncate = 2'd1;
  localparam logic [1:0] StatusTooLong  = 2'd2;
  localparam logic [1:0] StatusCapacity = 2'd3;

  typedef enum logic [1:0] {
    CMD_GAP,
    CMD_TRUNC,
    CMD_LONG
  } cmd_kind_e;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       buffer_end;
  } in_item_t;

  typedef struct packed {
    logic [AddrFieldWidth-1:0] address_value;
    logic [1:0]                decode_status;
    logic                      list_done;
  } out_item_t;

  // One classified code, handed from the front to the back.
  typedef struct packed {
    logic [AddrFieldWidth-1:0] gap;
    cmd_kind_e                 kind;
    logic                      last;
  } cmd_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic valid;
  } queue_status_t;

endpackage

### hdl/delta_varint_decoder.sv
// Top level of the delta varint posting-list decoder.
// Depends on dvd_pkg, dvd_front, dvd_cmd_queue and dvd_back.
//
// Usage:
// The input channel (in_valid_i, in_stall_o, in_item_i) takes one encoded byte
// per item. Each byte carries seven data bits, least significant group first;
// bit 7 set means the code continues. buffer_end marks the last byte of a list.
// The output channel (out_valid_o, out_stall_i, out_item_o) delivers one item
// for every closing byte and for a final byte: the running address, a status
// and list_done. Continuation bytes that are not final produce nothing.
// The list capacity register is written through cfg_valid_i / cfg_data_i; it
// is always ready and should only be written while the decoder is idle.
// Throughput is one byte per cycle while in_stall_o is low; the gather shift
// and OR sit in the front, the 64-bit add and the capacity compare in the
// back. An accepted byte's result is registered first in the command queue,
// then in the output register.
// When the receiver stalls, the result register holds and the two-entry queue
// fills; in_stall_o rises once the queue is full and drops as soon as an
// entry drains. Reset clears all gather and accumulation state, empties the
// queue and sets the capacity to its maximum.

module delta_varint_decoder #(
  parameter int unsigned AddrWidth = dvd_pkg::AddrWidthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  dvd_pkg::in_item_t            in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output dvd_pkg::out_item_t           out_item_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [dvd_pkg::CapWidth-1:0] cfg_data_i
);
  import dvd_pkg::*;

  logic          in_accept;
  logic          push;
  logic          pop;
  cmd_t          front_cmd;
  cmd_t          head_cmd;
  queue_status_t queue_status;

  // The capacity register is a plain flop, so a write can always land.
  assign cfg_ready_o = 1'b1;

  // Stall depends only on queue occupancy, never on the incoming valid.
  assign in_stall_o = queue_status.full;
  assign in_accept  = in_valid_i && !in_stall_o;

  dvd_front #(
    .AddrWidth (AddrWidth)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_accept),
    .in_item_i (in_item_i),
    .push_o    (push),
    .cmd_o     (front_cmd)
  );

  dvd_cmd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (front_cmd),
    .pop_i    (pop),
    .cmd_o    (head_cmd),
    .status_o (queue_status)
  );

  dvd_back #(
    .AddrWidth (AddrWidth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_write_i (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .queue_i     (queue_status),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

### hdl/dvd_front.sv
// Front end of the delta varint decoder: gathers data groups into a gap
// and classifies each finished code. Depends on dvd_pkg.

module dvd_front #(
  parameter int unsigned AddrWidth = dvd_pkg::AddrWidthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  dvd_pkg::in_item_t in_item_i,
  output logic             push_o,
  output dvd_pkg::cmd_t    cmd_o
);
  import dvd_pkg::*;

  localparam int unsigned ShiftWidth = AddrWidth + 7;

  logic [AddrWidth-1:0]  gap_q, gap_d;
  logic [PosWidth-1:0]   pos_q, pos_d;
  logic [6:0]            data;
  logic                  more;
  logic [ShiftWidth-1:0] placed;
  logic                  lost;
  logic [AddrWidth-1:0]  gap_next;
  logic [PosWidth-1:0]   pos_next;

  assign data = 7'(in_item_i.code_byte & DataMask);
  assign more = |(in_item_i.code_byte & MoreBit);

  // The group is placed at its bit position; anything landing at or above
  // the address width means the code cannot be represented.
  assign placed = ShiftWidth'(data) << pos_q;
  assign lost   = |placed[ShiftWidth-1:AddrWidth];

  always_comb begin
    gap_next = gap_q;
    pos_next = pos_q;
    if (pos_q == OverflowPos) begin
      pos_next = OverflowPos;
    end else if (pos_q >= PosWidth'(AddrWidth)) begin
      pos_next = OverflowPos;
    end else begin
      gap_next = gap_q | placed[AddrWidth-1:0];
      pos_next = lost ? OverflowPos : pos_q + GroupBits;
    end
  end

  always_comb begin
    push_o        = accept_i && (!more || in_item_i.buffer_end);
    cmd_o.gap     = AddrFieldWidth'(gap_next);
    cmd_o.last    = in_item_i.buffer_end;
    if (more) begin
      cmd_o.kind = CMD_TRUNC;
    end else if (pos_next == OverflowPos) begin
      cmd_o.kind = CMD_LONG;
    end else begin
      cmd_o.kind = CMD_GAP;
    end
    gap_d = gap_q;
    pos_d = pos_q;
    if (accept_i) begin
      if (push_o) begin
        gap_d = '0;
        pos_d = '0;
      end else begin
        gap_d = gap_next;
        pos_d = pos_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= '0;
      pos_q <= '0;
    end else begin
      gap_q <= gap_d;
      pos_q <= pos_d;
    end
  end

  // A code that is still being gathered never sits past the widest legal shift.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q != OverflowPos |-> pos_q <= PosWidth'(AddrWidth + 6))
    else $error("front: bit position out of range");

  // Handing a code to the queue restarts gathering from zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (gap_q == '0 && pos_q == '0))
    else $error("front: gather state not cleared after a code");

endmodule

### hdl/dvd_cmd_queue.sv
// Short command queue that decouples the decoder's front and back ends.
// Depends on dvd_pkg.

module dvd_cmd_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  dvd_pkg::cmd_t          cmd_i,
  input  logic                   pop_i,
  output dvd_pkg::cmd_t          cmd_o,
  output dvd_pkg::queue_status_t status_o
);
  import dvd_pkg::*;

  cmd_t                 entry_q [QueueDepth];
  logic [QPtrWidth-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrWidth-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntWidth-1:0] count_q, count_d;

  function automatic logic [QPtrWidth-1:0] next_ptr(input logic [QPtrWidth-1:0] ptr);
    logic [QPtrWidth-1:0] nxt;
    if (ptr == QPtrWidth'(QueueDepth - 1)) begin
      nxt = '0;
    end else begin
      nxt = ptr + 1'b1;
    end
    return nxt;
  endfunction

  assign status_o.full  = (count_q == QCntWidth'(QueueDepth));
  assign status_o.valid = (count_q != '0);
  assign cmd_o          = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? next_ptr(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |-> !status_o.full)
    else $error("queue: push into a full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> status_o.valid)
    else $error("queue: pop from an empty queue");

endmodule

### hdl/dvd_back.sv
// Back end of the delta varint decoder: accumulates gaps into addresses,
// enforces the list capacity and holds the result register. Depends on dvd_pkg.

module dvd_back #(
  parameter int unsigned AddrWidth = dvd_pkg::AddrWidthDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_write_i,
  input  logic [dvd_pkg::CapWidth-1:0]    cfg_data_i,
  input  dvd_pkg::queue_status_t          queue_i,
  input  dvd_pkg::cmd_t                   cmd_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output dvd_pkg::out_item_t              out_item_o
);
  import dvd_pkg::*;

  logic [CapWidth-1:0]  cap_q;
  logic [AddrWidth-1:0] total_q, total_d;
  logic [CapWidth-1:0]  count_q, count_d;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_item_q, out_item_d;
  logic [AddrWidth-1:0] sum;

  assign sum   = total_q + cmd_i.gap[AddrWidth-1:0];
  assign pop_o = queue_i.valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    total_d     = total_q;
    count_d     = count_q;
    out_item_d  = out_item_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (pop_o) begin
      out_valid_d              = 1'b1;
      out_item_d.address_value = '0;
      out_item_d.list_done     = cmd_i.last;
      unique case (cmd_i.kind)
        CMD_GAP: begin
          if (count_q >= cap_q) begin
            out_item_d.decode_status = StatusCapacity;
          end else begin
            total_d                  = sum;
            count_d                  = count_q + 1'b1;
            out_item_d.address_value = AddrFieldWidth'(sum);
            out_item_d.decode_status = StatusOk;
          end
        end
        CMD_TRUNC: out_item_d.decode_status = StatusTruncate;
        CMD_LONG:  out_item_d.decode_status = StatusTooLong;
        default:   out_item_d.decode_status = StatusTooLong;
      endcase
      if (cmd_i.last) begin
        total_d = '0;
        count_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CapReset;
      total_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_write_i) begin
        cap_q <= cfg_data_i;
      end
      total_q     <= total_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Only a successful decode carries an address.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.decode_status != StatusOk) |-> out_item_o.address_value == '0)
    else $error("back: failed decode carries an address");

  // Ending a list leaves the accumulator ready for the next one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && cmd_i.last) |=> (total_q == '0 && count_q == '0))
    else $error("back: list state not cleared at end of list");

endmodule

### sim/tb_top.sv
// Self-checking testbench for delta_varint_decoder: byte items in, address items out.
// Depends on dvd_pkg and the decoder RTL; its predictor is built in, so it reads no file.
`timescale 1ns / 100ps

module tb_top;
  import dvd_pkg::*;

  localparam int unsigned AddrW       = AddrWidthDefault;
  localparam logic [63:0] AddrMask    = {64{1'b1}} >> (64 - AddrW);
  // A result leaves through the command queue and the output register. Spare
  // cycles cover a continuation byte that is still in flight when the queue runs dry.
  localparam int          DrainCycles = 6;
  localparam int          IdleLimit   = 2000;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  in_item_t            in_item_i;
  logic                out_valid_o;
  logic                out_stall_i;
  out_item_t           out_item_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CapWidth-1:0] cfg_data_i;

  delta_varint_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Decoder state as the testbench predicts it. Gap bits gather into gap_acc
  // at shift_pos; a shift position of OverflowPos marks a code that no longer
  // fits the address width.
  logic [63:0]          gap_acc;
  logic [PosWidth-1:0]  shift_pos;
  logic [63:0]          addr_total;
  logic [CapWidth-1:0]  emitted_count;
  logic [CapWidth-1:0]  capacity_reg;

  out_item_t expected_results[$];
  int        errors;
  int        bytes_sent;
  bit        idle_enable;
  int        hold_cycles_req;

  // Works out what one accepted byte does to the decoder. A result is queued
  // for every closing byte and for every final byte; a continuation byte in
  // the middle of a list only gathers bits.
  function automatic void predict_byte(input in_item_t it);
    logic [63:0] grp;
    logic        more;
    int          room;
    out_item_t   res;
    grp  = 64'(it.code_byte & DataMask);
    more = (it.code_byte & MoreBit) != 0;
    res  = '0;

    if (shift_pos == OverflowPos) begin
      // The code already overflowed and stays marked until it closes.
    end else if (int'(shift_pos) >= int'(AddrW)) begin
      // Data arriving past the top of the address is always too long.
      shift_pos = OverflowPos;
    end else begin
      room    = int'(AddrW) - int'(shift_pos);
      gap_acc = (gap_acc | (grp << shift_pos)) & AddrMask;
      // Nonzero bits that would fall off the top also overflow the code.
      if (room < int'(GroupBits) && (grp >> room) != 0) begin
        shift_pos = OverflowPos;
      end else begin
        shift_pos = shift_pos + GroupBits;
      end
    end

    if (more && !it.buffer_end) return;

    res.list_done = it.buffer_end;
    if (more) begin
      // The list ended in the middle of a code.
      res.decode_status = StatusTruncate;
    end else if (shift_pos == OverflowPos) begin
      res.decode_status = StatusTooLong;
    end else if (emitted_count >= capacity_reg) begin
      // Past the capacity the gap is dropped and the total does not move.
      res.decode_status = StatusCapacity;
    end else begin
      addr_total          = (addr_total + gap_acc) & AddrMask;
      emitted_count       = emitted_count + 1;
      res.address_value   = addr_total;
      res.decode_status   = StatusOk;
    end

    gap_acc   = '0;
    shift_pos = '0;
    if (it.buffer_end) begin
      addr_total    = '0;
      emitted_count = '0;
    end
    expected_results.push_back(res);
  endfunction

  // Offers one byte and holds it until the decoder takes it. Now and then
  // the sender idles for a short burst first.
  task automatic send_byte(input logic [7:0] code, input logic last);
    in_item_t it;
    it.code_byte  = code;
    it.buffer_end = last;
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    predict_byte(it);
    bytes_sent++;
  endtask

  // Sends one code of the given length with random data; every byte but the
  // last carries the continuation bit.
  task automatic send_code(input int nbytes, input bit ends_list);
    logic [7:0] code;
    for (int k = 0; k < nbytes; k++) begin
      code = 8'($urandom_range(0, 127));
      if (k != nbytes - 1) code = code | MoreBit;
      send_byte(code, ends_list && (k == nbytes - 1));
    end
  endtask

  // Most codes are short, as real gaps are. Ten bytes reach the top of a
  // 64-bit address and may or may not overflow; longer ones always do.
  function automatic int pick_code_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 1;
    if (r < 85) return $urandom_range(2, 3);
    if (r < 94) return $urandom_range(4, 9);
    if (r < 97) return 10;
    return $urandom_range(11, 13);
  endfunction

  // One posting list: mostly well-formed codes that end on the final byte,
  // sometimes cut off inside a code, sometimes followed by raw noise.
  task automatic send_random_list();
    int ncodes;
    int shape;
    ncodes = $urandom_range(1, 8);
    shape  = $urandom_range(0, 19);
    for (int i = 0; i < ncodes; i++) begin
      send_code(pick_code_len(), (shape > 2) && (i == ncodes - 1));
    end
    if (shape == 0) begin
      repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(128, 255)), 1'b0);
      send_byte(8'($urandom_range(128, 255)), 1'b1);
    end else if (shape <= 2) begin
      repeat ($urandom_range(1, 6)) begin
        send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 3) == 0));
      end
    end
  endtask

  task automatic send_lists(input int nbytes);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < nbytes) send_random_list();
  endtask

  // Drops valid and waits until every predicted result has come out, then a
  // few more cycles so that nothing is left inside the decoder.
  task automatic wait_idle();
    int c;
    in_valid_i <= 1'b0;
    c = 0;
    while (expected_results.size() != 0 && c < IdleLimit) begin
      @(posedge clk_i);
      c++;
    end
    if (expected_results.size() != 0) begin
      $error("results missing: %0d still expected", expected_results.size());
      errors++;
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CapWidth-1:0] value);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    capacity_reg = value;
    cfg_valid_i <= 1'b0;
  endtask

  // Extremes of the byte and of the gap: zero, a full group, a two-byte
  // code, the largest gap (which wraps the total), a list cut off in a code
  // and a code too long on the final byte.
  task automatic test_directed();
    send_byte(8'h00, 1'b0);
    send_byte(DataMask, 1'b0);
    send_byte(MoreBit | 8'h01, 1'b0);
    send_byte(8'h01, 1'b0);
    repeat (9) send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(MoreBit, 1'b1);
    repeat (9) send_byte(8'hFF, 1'b0);
    send_byte(DataMask, 1'b1);
  endtask

  // Small capacities drop the entries of a list past its capacity; the largest
  // never drops any.
  task automatic test_capacity_limits();
    logic [CapWidth-1:0] caps[6];
    caps = '{32'd0, 32'd1, 32'd2, CapWidth'($urandom_range(3, 6)), CapWidth'($urandom()),
             CapReset};
    foreach (caps[i]) begin
      write_capacity(caps[i]);
      send_lists(110);
    end
  endtask

  task automatic test_random_stream();
    write_capacity(CapWidth'($urandom_range(4, 7)));
    send_lists(150);
    write_capacity(CapReset);
    send_lists(500);
  endtask

  // The receiver holds off for a long stretch while short codes keep
  // coming, so the queue fills and the decoder stalls its input.
  task automatic test_backpressure();
    wait_idle();
    hold_cycles_req = 80;
    repeat (40) send_byte(8'($urandom_range(0, 127)), 1'b0);
    send_lists(40);
  endtask

  // Last part at full rate: neither side idles.
  task automatic test_full_rate();
    wait_idle();
    idle_enable = 1'b0;
    send_lists(200);
    send_byte(8'($urandom_range(0, 127)), 1'b1);
  endtask

  // Receiver side: random stall bursts, or a long hold when one is asked for.
  initial begin : receiver_side
    int n;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles_req != 0) begin
        n = hold_cycles_req;
        hold_cycles_req = 0;
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Every accepted result is compared with the oldest prediction.
  always @(posedge clk_i) begin
    out_item_t exp_item;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: address %h status %0d done %0b",
               out_item_o.address_value, out_item_o.decode_status, out_item_o.list_done);
        errors++;
      end else begin
        exp_item = expected_results.pop_front();
        if (out_item_o.address_value !== exp_item.address_value) begin
          $error("address_value: expected %h, got %h",
                 exp_item.address_value, out_item_o.address_value);
          errors++;
        end
        if (out_item_o.decode_status !== exp_item.decode_status) begin
          $error("decode_status: expected %0d, got %0d",
                 exp_item.decode_status, out_item_o.decode_status);
          errors++;
        end
        if (out_item_o.list_done !== exp_item.list_done) begin
          $error("list_done: expected %0b, got %0b",
                 exp_item.list_done, out_item_o.list_done);
          errors++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    in_item_i       = '0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    errors          = 0;
    bytes_sent      = 0;
    idle_enable     = 1'b1;
    hold_cycles_req = 0;
    gap_acc         = '0;
    shift_pos       = '0;
    addr_total      = '0;
    emitted_count   = '0;
    capacity_reg    = CapReset;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_capacity_limits();
    test_random_stream();
    test_backpressure();
    test_full_rate();

    wait_idle();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
hdl/dvd_pkg.sv
hdl/dvd_front.sv
hdl/dvd_cmd_queue.sv
hdl/dvd_back.sv
hdl/delta_varint_decoder.sv
sim/tb_top.sv
